// File: rtl/core/multiband_time_histogram_macros.svh
// Assertion macros shared by the checker files of the histogram block.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef MULTIBAND_TIME_HISTOGRAM_MACROS_SVH
`define MULTIBAND_TIME_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mth_pkg.sv
package mth_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 1024;
    localparam int unsigned MAX_BANDS_DEF = 4;
    localparam int unsigned NUM_ENERGY_IN = 4;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned FACTOR_W   = 24;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned SC_W       = 11;
    localparam int unsigned BC_W       = 3;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SLOT_IDX_W = 10;
    localparam int unsigned INTEG_W    = 2 * DATA_W;

    localparam int unsigned S_TDATA_W = DATA_W * (NUM_ENERGY_IN + 1) + FACTOR_W;
    localparam int unsigned M_TDATA_W =
        ((SLOT_IDX_W + NUM_ENERGY_IN * INTEG_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_MAX       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_SCALE     = 3'd3;
    localparam logic [OP_W-1:0] OP_INTEGRATE = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_COUNT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_SLOT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SLOT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_TIME  = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_CHECK,
        ST_RMW,
        ST_SCALE,
        ST_SUM,
        ST_INT_LO,
        ST_INT_HI,
        ST_INT_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_ADD,
        WR_MAX,
        WR_SCALE
    } wr_sel_t;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_LO,
        MUL_HI
    } mul_sel_t;

    // Per-cycle commands from the sequencer to every band lane.
    typedef struct packed {
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_en;
        logic     int_lo;
        logic     int_hi;
    } lane_ctl_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic                  load;
        logic                  status;
        logic                  integ;
        logic [SLOT_IDX_W-1:0] slot;
    } res_t;

endpackage

// File: rtl/core/mth_ram.sv
module mth_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mth_lane.sv
module mth_lane import mth_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    localparam int unsigned ADDR_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int unsigned CNT_W    = $clog2(MAX_SLOTS + 1)
) (
    input  logic                clk,
    input  lane_ctl_t           ctl,
    input  logic                band_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [DATA_W-1:0]   energy,
    input  logic [FACTOR_W-1:0] factor,
    input  logic [DATA_W-1:0]   slot_time,
    output logic [INTEG_W-1:0]  integral
);

    localparam int unsigned SUM_W = DATA_W + CNT_W;

    logic [DATA_W-1:0]   rd_data;
    logic [DATA_W-1:0]   wr_data;
    logic                wr_en;
    logic [DATA_W:0]     add_sum;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [INTEG_W-1:0]  product;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [INTEG_W-1:0]  mul_reg;
    logic [INTEG_W-1:0]  mul_next;
    logic [INTEG_W-1:0]  integ_reg;
    logic [INTEG_W-1:0]  integ_next;

    mth_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SLOTS)
    ) u_bank (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign add_sum = {1'b0, rd_data} + {1'b0, energy};

    // Bands that are not in use keep their contents on add and max.
    assign wr_en = ctl.wr_en &&
        (band_en || ctl.wr_sel == WR_ZERO || ctl.wr_sel == WR_SCALE);

    always_comb
    begin
        case (ctl.wr_sel)
            WR_ZERO:  wr_data = '0;
            WR_ADD:   wr_data = add_sum[DATA_W] ? '1 : add_sum[DATA_W-1:0];
            WR_MAX:   wr_data = (energy > rd_data) ? energy : rd_data;
            WR_SCALE: wr_data = (|mul_reg[INTEG_W-1:DATA_W+FRAC_W]) ? '1 :
                                mul_reg[DATA_W+FRAC_W-1:FRAC_W];
            default:  wr_data = '0;
        endcase
    end

    // One multiplier serves scaling and both halves of the integral.
    always_comb
    begin
        case (ctl.mul_sel)
            MUL_SCALE:
            begin
                mul_a = rd_data;
                mul_b = DATA_W'(factor);
            end
            MUL_LO:
            begin
                mul_a = acc_reg[DATA_W-1:0];
                mul_b = slot_time;
            end
            MUL_HI:
            begin
                mul_a = DATA_W'(acc_reg[SUM_W-1:DATA_W]);
                mul_b = slot_time;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg + SUM_W'(rd_data);
        end

        mul_next = ctl.mul_en ? product : mul_reg;

        integ_next = integ_reg;
        if (ctl.int_lo)
        begin
            integ_next = mul_reg >> FRAC_W;
        end
        else if (ctl.int_hi)
        begin
            integ_next = integ_reg + (mul_reg << FRAC_W);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mul_reg   <= mul_next;
        integ_reg <= integ_next;
    end

    assign integral = integ_reg;

endmodule

// File: rtl/core/mth_ctrl.sv
module mth_ctrl import mth_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int unsigned MAX_BANDS = MAX_BANDS_DEF,
    localparam int unsigned ADDR_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int unsigned CNT_W    = $clog2(MAX_SLOTS + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [OP_W-1:0]                       s_op,
    input  logic [DATA_W-1:0]                     s_arrival_time,
    input  logic [NUM_ENERGY_IN-1:0][DATA_W-1:0]  s_energy,
    input  logic [FACTOR_W-1:0]                   s_scale_factor,
    input  logic                                  out_free,
    output lane_ctl_t                             ctl,
    output logic [ADDR_W-1:0]                     rd_addr,
    output logic [ADDR_W-1:0]                     wr_addr,
    output logic [MAX_BANDS-1:0]                  band_en,
    output logic [NUM_ENERGY_IN-1:0][DATA_W-1:0]  energy,
    output logic [FACTOR_W-1:0]                   factor,
    output logic [DATA_W-1:0]                     slot_time,
    output res_t                                  res
);

    localparam int unsigned BCNT_W = $clog2(MAX_BANDS + 1);

    logic [SC_W-1:0]   slot_count_reg;
    logic [BC_W-1:0]   band_count_reg;
    logic [DATA_W-1:0] half_slot_reg;
    logic [DATA_W-1:0] inv_slot_reg;
    logic [DATA_W-1:0] slot_time_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;
    logic              busy_reg;
    logic              busy_next;
    logic              drop_reg;
    logic              drop_next;

    logic [OP_W-1:0]                      op_reg;
    logic [DATA_W-1:0]                    d_reg;
    logic                                 neg_reg;
    logic [DATA_W-1:0]                    slot_reg;
    logic [NUM_ENERGY_IN-1:0][DATA_W-1:0] energy_reg;
    logic [FACTOR_W-1:0]                  factor_reg;
    logic [ADDR_W-1:0]                    a1_reg;
    logic [ADDR_W-1:0]                    a2_reg;

    logic                 item_load;
    logic                 slot_load;
    logic                 issuing;
    logic                 geom_change;
    logic [CNT_W-1:0]     nslots;
    logic [BCNT_W-1:0]    nbands;
    logic [INTEG_W-1:0]   map_prod;

    always_comb
    begin
        if (32'(slot_count_reg) > 32'(MAX_SLOTS))
        begin
            nslots = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            nslots = CNT_W'(slot_count_reg);
        end

        if (band_count_reg == '0)
        begin
            nbands = BCNT_W'(1);
        end
        else if (32'(band_count_reg) > 32'(MAX_BANDS))
        begin
            nbands = BCNT_W'(MAX_BANDS);
        end
        else
        begin
            nbands = BCNT_W'(band_count_reg);
        end
    end

    for (genvar b = 0; b < MAX_BANDS; b++)
    begin : g_band_en
        assign band_en[b] = 32'(nbands) > 32'(b);
    end

    // Changing the geometry invalidates the whole store.
    assign geom_change = cfg_wr_en &&
        ((cfg_addr == REG_SLOT_COUNT && cfg_wdata[SC_W-1:0] != slot_count_reg) ||
         (cfg_addr == REG_BAND_COUNT && cfg_wdata[BC_W-1:0] != band_count_reg));

    assign map_prod = d_reg * inv_slot_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v1_next    = 1'b0;
        v2_next    = 1'b0;
        busy_next  = busy_reg;
        drop_next  = drop_reg;
        item_load  = 1'b0;
        slot_load  = 1'b0;
        issuing    = 1'b0;
        s_tready   = 1'b0;
        ctl        = '0;
        res        = '0;
        rd_addr    = cnt_reg[ADDR_W-1:0];
        wr_addr    = cnt_reg[ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_ZERO;
                if (32'(cnt_reg) == 32'(MAX_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = busy_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    item_load = 1'b1;
                    cnt_next  = '0;
                    drop_next = 1'b0;
                    busy_next = 1'b0;
                    case (s_op)
                        OP_ADD, OP_MAX:
                        begin
                            state_next = ST_MAP;
                        end
                        OP_CLEAR:
                        begin
                            busy_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        OP_SCALE:
                        begin
                            state_next = ST_SCALE;
                        end
                        OP_INTEGRATE:
                        begin
                            ctl.acc_clr = 1'b1;
                            state_next  = ST_SUM;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MAP:
            begin
                slot_load  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                rd_addr = slot_reg[ADDR_W-1:0];
                if (slot_reg >= 32'(nslots))
                begin
                    drop_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = (op_reg == OP_MAX) ? WR_MAX : WR_ADD;
                wr_addr    = slot_reg[ADDR_W-1:0];
                state_next = ST_DONE;
            end
            ST_SCALE:
            begin
                // Read, multiply and write back run as a three-stage sweep.
                issuing = 32'(cnt_reg) < 32'(MAX_SLOTS);
                v1_next = issuing;
                v2_next = v1_reg;
                if (issuing)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (v1_reg)
                begin
                    ctl.mul_en  = 1'b1;
                    ctl.mul_sel = MUL_SCALE;
                end
                if (v2_reg)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WR_SCALE;
                    wr_addr    = a2_reg;
                end
                if (!issuing && !v1_reg && !v2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SUM:
            begin
                issuing    = 32'(cnt_reg) < 32'(nslots);
                v1_next    = issuing;
                ctl.acc_en = v1_reg;
                if (issuing)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (!issuing && !v1_reg)
                begin
                    state_next = ST_INT_LO;
                end
            end
            ST_INT_LO:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_LO;
                state_next  = ST_INT_HI;
            end
            ST_INT_HI:
            begin
                ctl.int_lo  = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_HI;
                state_next  = ST_INT_ADD;
            end
            ST_INT_ADD:
            begin
                ctl.int_hi = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res.status = drop_reg;
                res.integ  = (op_reg == OP_INTEGRATE);
                res.slot   = ((op_reg == OP_ADD || op_reg == OP_MAX) && !drop_reg) ?
                             slot_reg[SLOT_IDX_W-1:0] : '0;
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A clearing pass started by the registers never produces a result.
        if (geom_change)
        begin
            cnt_next   = '0;
            busy_next  = 1'b0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            busy_reg       <= 1'b0;
            drop_reg       <= 1'b0;
            slot_count_reg <= '0;
            band_count_reg <= BC_W'(1);
            half_slot_reg  <= '0;
            inv_slot_reg   <= '0;
            slot_time_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            busy_reg  <= busy_next;
            drop_reg  <= drop_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_SLOT_COUNT: slot_count_reg <= cfg_wdata[SC_W-1:0];
                    REG_BAND_COUNT: band_count_reg <= cfg_wdata[BC_W-1:0];
                    REG_HALF_SLOT:  half_slot_reg  <= cfg_wdata[DATA_W-1:0];
                    REG_INV_SLOT:   inv_slot_reg   <= cfg_wdata[DATA_W-1:0];
                    REG_SLOT_TIME:  slot_time_reg  <= cfg_wdata[DATA_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            op_reg     <= s_op;
            d_reg      <= s_arrival_time - half_slot_reg;
            neg_reg    <= s_arrival_time < half_slot_reg;
            energy_reg <= s_energy;
            factor_reg <= s_scale_factor;
        end
        if (slot_load)
        begin
            slot_reg <= neg_reg ? '0 : map_prod[INTEG_W-1:DATA_W];
        end
        a1_reg <= cnt_reg[ADDR_W-1:0];
        a2_reg <= a1_reg;
    end

    assign energy    = energy_reg;
    assign factor    = factor_reg;
    assign slot_time = slot_time_reg;

endmodule

// File: rtl/core/multiband_time_histogram.sv
// Add and max pass through the map, check and read-modify-write states; a dropped
// item skips the write. Clear zeroes all MAX_SLOTS slots, scale sweeps them all
// (one slot of every band bank per cycle), integrate sums the slots in use, and an
// unknown op goes straight to done. One item is in flight at a time; the next is
// taken once the result is registered.
// After reset, and after a slot or band count change, all MAX_SLOTS slots are cleared first.
module multiband_time_histogram import mth_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int unsigned MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // arrival_time, energy_0, energy_1, energy_2, energy_3, scale_factor
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_index, integral_0, integral_1, integral_2, integral_3, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic                  m_tuser
);

    localparam int unsigned ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [NUM_ENERGY_IN-1:0][DATA_W-1:0]  s_energy;
    logic [NUM_ENERGY_IN-1:0][DATA_W-1:0]  energy;
    logic [MAX_BANDS-1:0][INTEG_W-1:0]     lane_integral;
    logic [NUM_ENERGY_IN-1:0][INTEG_W-1:0] out_integ;
    logic [MAX_BANDS-1:0]                  band_en;
    logic [ADDR_W-1:0]                     rd_addr;
    logic [ADDR_W-1:0]                     wr_addr;
    logic [FACTOR_W-1:0]                   factor;
    logic [DATA_W-1:0]                     slot_time;
    lane_ctl_t                             ctl;
    res_t                                  res;
    logic                                  out_free;

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    for (genvar e = 0; e < NUM_ENERGY_IN; e++)
    begin : g_unpack
        assign s_energy[e] = s_tdata[DATA_W*(e+2)-1 -: DATA_W];
    end

    mth_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_op           (s_tuser),
        .s_arrival_time (s_tdata[DATA_W-1:0]),
        .s_energy       (s_energy),
        .s_scale_factor (s_tdata[DATA_W*(NUM_ENERGY_IN+1) +: FACTOR_W]),
        .out_free       (out_free),
        .ctl            (ctl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .band_en        (band_en),
        .energy         (energy),
        .factor         (factor),
        .slot_time      (slot_time),
        .res            (res)
    );

    for (genvar b = 0; b < MAX_BANDS; b++)
    begin : g_lane
        logic [DATA_W-1:0] lane_energy;

        // Bands past the energy inputs see zero energy.
        if (b < NUM_ENERGY_IN)
        begin : g_energy
            assign lane_energy = energy[b];
        end
        else
        begin : g_no_energy
            assign lane_energy = '0;
        end

        mth_lane #(
            .MAX_SLOTS (MAX_SLOTS)
        ) u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .band_en   (band_en[b]),
            .rd_addr   (rd_addr),
            .wr_addr   (wr_addr),
            .energy    (lane_energy),
            .factor    (factor),
            .slot_time (slot_time),
            .integral  (lane_integral[b])
        );
    end

    for (genvar b = 0; b < NUM_ENERGY_IN; b++)
    begin : g_out
        if (b < MAX_BANDS)
        begin : g_used
            assign out_integ[b] = (res.integ && band_en[b]) ? lane_integral[b] : '0;
        end
        else
        begin : g_unused
            assign out_integ[b] = '0;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res.load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            m_tdata_reg <= M_TDATA_W'({out_integ, res.slot});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/core/mth_checker.sv
`include "multiband_time_histogram_macros.svh"

module mth_checker import mth_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A stalled result must not change under the consumer.
    `MTH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Items are worked one at a time, so ready drops right after a transaction.
    `MTH_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    // A dropped add or max reports no slot and no integrals.
    `MTH_ASSERT_IMP(a_drop_clean, m_tvalid && m_tuser, m_tdata == '0, "dropped result carries data")

    // A fresh result never appears in the cycle right after an input transaction.
    `MTH_ASSERT_IMP(a_no_instant, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result too early")

endmodule

bind multiband_time_histogram mth_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
